// File: rtl/scfp_pkg.sv
// Shared types and constants for the serial command frame parser.
// Used by the framer, the top level and the bench; depends on nothing.

package scfp_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h4B;
    localparam logic [7:0] HDR_SECOND  = 8'h4D;
    localparam logic [7:0] VERIFY_MARK = 8'h96;
    localparam logic [7:0] LONG_MARK   = 8'd23;
    localparam logic [7:0] WIFI_MARK   = 8'd1;
    localparam logic [7:0] HDR_SUM     = HDR_FIRST + HDR_SECOND;

    localparam logic [15:0] LIMIT_RESET = 16'd5000;

    // Byte positions within a frame.
    localparam logic [3:0] POS_LEN     = 4'd2;
    localparam logic [3:0] POS_ID      = 4'd3;
    localparam logic [3:0] POS_VAL0    = 4'd4;
    localparam logic [3:0] POS_VAL1    = 4'd5;
    localparam logic [3:0] POS_VAL2    = 4'd6;
    localparam logic [3:0] POS_VAL3    = 4'd7;
    localparam logic [3:0] POS_VERIFYL = 4'd8;
    localparam logic [3:0] LAST_SHORT  = 4'd7;
    localparam logic [3:0] LAST_LONG   = 4'd10;

    // Setting ids carried by long frames.
    localparam logic [7:0] ID_TIME      = 8'd0;
    localparam logic [7:0] ID_REST      = 8'd1;
    localparam logic [7:0] ID_VERSION   = 8'd3;
    localparam logic [7:0] ID_HEARTBEAT = 8'd4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GOT1,
        PH_BODY
    } phase_t;

    typedef struct packed {
        logic        long_frame;
        logic [7:0]  id;
        logic [7:0]  len_byte;
        logic [31:0] value;
    } frame_event_t;

endpackage

// File: rtl/scfp_if.sv
// Handshake channels of the serial command frame parser: received bytes,
// results and the heartbeat limit write port. No dependencies.

interface scfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_result_if;
    logic        valid;
    logic        ready;
    logic        frame_kind;
    logic [7:0]  event_id;
    logic [7:0]  event_value;
    logic [31:0] current_time;
    logic [31:0] rest_count;
    logic [31:0] api_version;
    logic [15:0] heartbeat_count;
    logic        wifi_flag;

    modport source (output valid, output frame_kind, output event_id, output event_value,
                    output current_time, output rest_count, output api_version,
                    output heartbeat_count, output wifi_flag, input ready);
    modport sink   (input valid, input frame_kind, input event_id, input event_value,
                    input current_time, input rest_count, input api_version,
                    input heartbeat_count, input wifi_flag, output ready);
endinterface

interface scfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] heartbeat_limit;

    modport source (output valid, output heartbeat_limit, input ready);
    modport sink   (input valid, input heartbeat_limit, output ready);
endinterface

// File: rtl/scfp_framer.sv
// Header hunt, frame capture, checksum and verify-mark check for the frame parser.
// Depends on scfp_pkg; emits one registered event per valid frame.

module scfp_framer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_accept,
    input  logic [7:0]            rx_byte,
    input  logic                  ev_take,
    output logic                  ev_valid,
    output scfp_pkg::frame_event_t ev
);
    import scfp_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [3:0]   count_reg, count_next;
    logic         long_reg, long_next;
    logic [7:0]   sum_reg, sum_next;
    logic [7:0]   len_reg;
    logic [7:0]   id_reg;
    logic [7:0]   byte8_reg;
    logic [7:0]   data_reg [0:3];
    logic         ev_valid_reg, ev_valid_next;
    frame_event_t ev_reg;

    logic         long_eff;
    logic         is_last;
    logic         frame_good;
    logic [7:0]   verify_byte;

    // The length byte decides the frame length in the same cycle it arrives.
    assign long_eff    = (count_reg == POS_LEN) ? (rx_byte == LONG_MARK) : long_reg;
    assign is_last     = (phase_reg == PH_BODY) &&
                         (count_reg == (long_eff ? LAST_LONG : LAST_SHORT));
    assign verify_byte = long_eff ? byte8_reg : data_reg[1];
    assign frame_good  = byte_accept && is_last && (sum_reg == rx_byte) &&
                         (verify_byte == VERIFY_MARK);

    always_comb
    begin
        phase_next = phase_reg;
        if (byte_accept)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == HDR_FIRST)
                        phase_next = PH_GOT1;
                end
                PH_GOT1:
                begin
                    if (rx_byte == HDR_SECOND)
                        phase_next = PH_BODY;
                    else if (rx_byte != HDR_FIRST)
                        phase_next = PH_IDLE;
                end
                PH_BODY:
                begin
                    if (is_last)
                        phase_next = PH_IDLE;
                end
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        long_next  = long_reg;
        sum_next   = sum_reg;
        if (byte_accept)
        begin
            if (phase_reg == PH_GOT1 && rx_byte == HDR_SECOND)
            begin
                count_next = POS_LEN;
                long_next  = 1'b0;
                sum_next   = HDR_SUM;
            end
            else if (phase_reg == PH_BODY)
            begin
                long_next = long_eff;
                if (is_last)
                begin
                    count_next = 4'd0;
                end
                else
                begin
                    count_next = count_reg + 4'd1;
                    sum_next   = sum_reg + rx_byte;
                end
            end
        end
        ev_valid_next = (ev_valid_reg && !ev_take) || frame_good;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            count_reg    <= 4'd0;
            long_reg     <= 1'b0;
            sum_reg      <= 8'd0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            long_reg     <= long_next;
            sum_reg      <= sum_next;
            ev_valid_reg <= ev_valid_next;
        end
    end

    // Frame body capture; only the bytes that the result and the verify check need are kept.
    always_ff @(posedge clk)
    begin
        if (byte_accept && phase_reg == PH_BODY)
        begin
            unique case (count_reg)
                POS_LEN:     len_reg     <= rx_byte;
                POS_ID:      id_reg      <= rx_byte;
                POS_VAL0:    data_reg[0] <= rx_byte;
                POS_VAL1:    data_reg[1] <= rx_byte;
                POS_VAL2:    data_reg[2] <= rx_byte;
                POS_VAL3:    data_reg[3] <= rx_byte;
                POS_VERIFYL: byte8_reg   <= rx_byte;
                default:     ;
            endcase
        end
        if (frame_good)
        begin
            ev_reg.long_frame <= long_eff;
            ev_reg.id         <= id_reg;
            ev_reg.len_byte   <= len_reg;
            // For a short frame only the top byte (event value) is meaningful.
            ev_reg.value      <= {data_reg[0], data_reg[1], data_reg[2], data_reg[3]};
        end
    end

    assign ev_valid = ev_valid_reg;
    assign ev       = ev_reg;

endmodule

// File: rtl/serial_command_frame_parser.sv
// Serial command frame parser, top level: framer plus settings stage.
// A result is held in the framer's event register, then in the output registers.
// Throughput: one byte per cycle; ready falls only while both stages hold items.
// The settings registers double as the result register, so no extra copy exists.
// Reset (rst_n, asynchronous): hunt restarts, settings clear, limit returns to 5000.
// Depends on scfp_pkg, scfp_if and scfp_framer.

module serial_command_frame_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    scfp_byte_if.sink            rx,
    scfp_result_if.source        res,
    scfp_cfg_if.sink             cfg
);
    import scfp_pkg::*;

    logic         ev_valid;
    frame_event_t ev;
    logic         ev_take;
    logic         load;

    logic         out_valid_reg, out_valid_next;
    logic [15:0]  limit_reg;
    logic         kind_reg;
    logic [7:0]   id_reg;
    logic [7:0]   value_reg;
    logic [31:0]  time_reg, time_next;
    logic [31:0]  rest_reg, rest_next;
    logic [31:0]  version_reg, version_next;
    logic [15:0]  hb_reg, hb_next;
    logic         wifi_reg, wifi_next;
    logic [15:0]  hb_inc;

    assign ev_take  = !out_valid_reg || res.ready;
    assign load     = ev_valid && ev_take;
    assign rx.ready = !ev_valid || ev_take;
    assign cfg.ready = 1'b1;

    scfp_framer u_framer (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (rx.valid && rx.ready),
        .rx_byte     (rx.rx_byte),
        .ev_take     (ev_take),
        .ev_valid    (ev_valid),
        .ev          (ev)
    );

    assign hb_inc = hb_reg + 16'd1;

    always_comb
    begin
        time_next    = time_reg;
        rest_next    = rest_reg;
        version_next = version_reg;
        hb_next      = hb_reg;
        wifi_next    = wifi_reg;
        if (load && ev.long_frame)
        begin
            unique case (ev.id)
                ID_TIME:    time_next    = ev.value;
                ID_REST:    rest_next    = ev.value;
                ID_VERSION: version_next = ev.value;
                ID_HEARTBEAT:
                begin
                    if (hb_inc > limit_reg)
                    begin
                        hb_next   = 16'd0;
                        wifi_next = (ev.len_byte == WIFI_MARK);
                    end
                    else
                    begin
                        hb_next = hb_inc;
                    end
                end
                default: ;
            endcase
        end
        out_valid_next = ev_take ? ev_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            time_reg      <= 32'd0;
            rest_reg      <= 32'd0;
            version_reg   <= 32'd0;
            hb_reg        <= 16'd0;
            wifi_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                limit_reg <= cfg.heartbeat_limit;
            time_reg    <= time_next;
            rest_reg    <= rest_next;
            version_reg <= version_next;
            hb_reg      <= hb_next;
            wifi_reg    <= wifi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= ev.long_frame;
            id_reg    <= ev.id;
            value_reg <= ev.value[31:24];
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.frame_kind      = kind_reg;
    assign res.event_id        = id_reg;
    assign res.event_value     = value_reg;
    assign res.current_time    = time_reg;
    assign res.rest_count      = rest_reg;
    assign res.api_version     = version_reg;
    assign res.heartbeat_count = hb_reg;
    assign res.wifi_flag       = wifi_reg;

    // A byte is only taken when the event stage has room for its frame.
    a_no_event_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rx.valid && rx.ready) |-> (!ev_valid || ev_take))
        else $error("byte transfer while event stage is blocked");

    // Settings move only when a result is loaded.
    a_settings_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> ($stable(hb_reg) && $stable(time_reg) && $stable(wifi_reg)))
        else $error("settings changed without a result");

    // A long frame always carries the long mark, so the wifi flag can never be set.
    a_wifi_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !wifi_reg)
        else $error("wifi flag set");

endmodule

// File: bench/tb_serial_command_frame_parser.sv
`timescale 1ns / 1ps
// Self-checking bench for serial_command_frame_parser: a table of directed frames, then random
// framed traffic and noise under bursty input and stalled output, checked by a frame predictor.
// Depends on scfp_pkg, the channel interfaces in scfp_if and the top level module.

module tb_serial_command_frame_parser;

    import scfp_pkg::*;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 9;
    localparam int SETTLE_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HOLD_AFTER_BYTES = 400;
    localparam int HOLD_CYCLES      = 400;
    localparam int PHASE_BYTES      = 85;
    localparam int REPORT_LINES     = 40;

    localparam logic [7:0]  SYNC_A      = 8'h4B;
    localparam logic [7:0]  SYNC_B      = 8'h4D;
    localparam logic [7:0]  CHECK_MARK  = 8'h96;
    localparam logic [7:0]  LONG_TAG    = 8'd23;
    localparam logic [7:0]  WIFI_TAG    = 8'd1;
    localparam logic [15:0] RESET_LIMIT = 16'd5000;

    localparam logic [3:0] LEN_AT         = 4'd2;
    localparam logic [3:0] ID_AT          = 4'd3;
    localparam logic [3:0] VALUE_AT       = 4'd4;
    localparam logic [3:0] SHORT_CHECK_AT = 4'd5;
    localparam logic [3:0] LONG_CHECK_AT  = 4'd8;
    localparam logic [3:0] SHORT_LAST     = 4'd7;
    localparam logic [3:0] LONG_LAST      = 4'd10;

    localparam logic [7:0] SET_TIME    = 8'd0;
    localparam logic [7:0] SET_REST    = 8'd1;
    localparam logic [7:0] SET_VERSION = 8'd3;
    localparam logic [7:0] SET_BEAT    = 8'd4;

    typedef enum logic [1:0] {FAULT_NONE, FAULT_SUM, FAULT_MARK} fault_t;
    typedef enum logic [1:0] {CHECK_MODEL, CHECK_TYPED, CHECK_NONE} check_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  id;
        logic [7:0]  value;
        logic [31:0] time_val;
        logic [31:0] rest;
        logic [31:0] version;
        logic [15:0] beats;
        logic        wifi;
    } frame_result_t;

    typedef struct packed {
        logic          is_long;
        logic [7:0]    len_byte;
        logic [7:0]    id;
        logic [31:0]   value;
        logic [7:0]    pad;
        logic [1:0]    lead;
        fault_t        fault;
        check_t        check;
        frame_result_t want;
    } frame_row_t;

    localparam frame_result_t NO_RESULT = '0;

    // The value byte of a frame is value[31:24]; long frames carry all four bytes.
    localparam frame_row_t DIRECTED_ROWS [18] = '{
        '{1'b0, 8'h00, 8'hFF, 32'hFF00_0000, 8'hFF, 2'd0, FAULT_NONE, CHECK_TYPED,
          '{1'b0, 8'hFF, 8'hFF, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0}},
        '{1'b0, 8'hFF, 8'h00, 32'h0000_0000, 8'h00, 2'd1, FAULT_NONE, CHECK_TYPED,
          '{1'b0, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 1'b0}},
        '{1'b1, LONG_TAG, SET_TIME, 32'hFFFF_FFFF, 8'h00, 2'd0, FAULT_NONE, CHECK_TYPED,
          '{1'b1, SET_TIME, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 1'b0}},
        '{1'b1, LONG_TAG, SET_REST, 32'h0000_0000, 8'h55, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b1, LONG_TAG, SET_REST, 32'h8000_0001, 8'hAA, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b1, LONG_TAG, SET_VERSION, 32'hFFFF_FFFF, 8'hFF, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b1, LONG_TAG, SET_BEAT, 32'h0000_0000, 8'h00, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b1, LONG_TAG, SET_BEAT, 32'hFFFF_FFFF, 8'hFF, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b1, LONG_TAG, 8'h02, 32'h1234_5678, 8'h0F, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b1, LONG_TAG, 8'hFF, 32'hFFFF_FFFF, 8'hF0, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b0, 8'd22, SET_TIME, 32'h5A00_0000, 8'h3C, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b0, 8'd24, SET_BEAT, 32'hC300_0000, 8'h81, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b0, WIFI_TAG, 8'h07, 32'h0000_0000, 8'h7E, 2'd0, FAULT_NONE, CHECK_MODEL,
          NO_RESULT},
        '{1'b0, 8'h00, 8'h00, 32'h0000_0000, 8'h00, 2'd0, FAULT_SUM, CHECK_NONE,
          NO_RESULT},
        '{1'b1, LONG_TAG, SET_TIME, 32'h0000_0000, 8'h00, 2'd0, FAULT_SUM, CHECK_NONE,
          NO_RESULT},
        '{1'b0, 8'h10, 8'h20, 32'h3000_0000, 8'h40, 2'd0, FAULT_MARK, CHECK_NONE,
          NO_RESULT},
        '{1'b1, LONG_TAG, SET_REST, 32'hDEAD_BEEF, 8'h11, 2'd0, FAULT_MARK, CHECK_NONE,
          NO_RESULT},
        '{1'b1, LONG_TAG, SET_TIME, 32'h0000_0000, 8'h99, 2'd2, FAULT_NONE, CHECK_MODEL,
          NO_RESULT}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    scfp_byte_if   rx_ch ();
    scfp_result_if res_ch ();
    scfp_cfg_if    cfg_ch ();

    serial_command_frame_parser DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #CLK_HALF clk = ~clk;

    // Predictor state.
    phase_t      hunt;
    logic [3:0]  fill_idx;
    logic        long_seen;
    logic [7:0]  csum;
    logic [7:0]  frame_buf [0:10];
    logic [31:0] time_set;
    logic [31:0] rest_set;
    logic [31:0] version_set;
    logic [15:0] beat_count;
    logic        wifi_set;
    logic [15:0] beat_limit;

    logic [7:0]    frame_q [$];
    logic [7:0]    line_bytes [$];
    frame_result_t awaited_results [$];
    int            bytes_queued = 0;
    int            bytes_accepted = 0;
    int            mismatches = 0;
    logic          hold_off = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < REPORT_LINES)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advances the predictor by one received byte; got is set when a valid frame completes.
    task automatic parse_byte(input logic [7:0] b, output bit got, output frame_result_t r);
        logic [3:0]  last_at;
        logic [31:0] word;
        got = 1'b0;
        r = '0;
        case (hunt)
            PH_IDLE:
            begin
                if (b == SYNC_A)
                    hunt = PH_GOT1;
            end
            PH_GOT1:
            begin
                if (b == SYNC_B)
                begin
                    hunt = PH_BODY;
                    frame_buf[0] = SYNC_A;
                    frame_buf[1] = SYNC_B;
                    csum = SYNC_A + SYNC_B;
                    fill_idx = LEN_AT;
                    long_seen = 1'b0;
                end
                else if (b != SYNC_A)
                begin
                    hunt = PH_IDLE;
                end
            end
            default:
            begin
                if (fill_idx == LEN_AT)
                    long_seen = (b == LONG_TAG);
                last_at = long_seen ? LONG_LAST : SHORT_LAST;
                frame_buf[fill_idx] = b;
                if (fill_idx < last_at)
                begin
                    csum = csum + b;
                    fill_idx = fill_idx + 4'd1;
                end
                else
                begin
                    hunt = PH_IDLE;
                    fill_idx = '0;
                    if (csum == b &&
                        frame_buf[long_seen ? LONG_CHECK_AT : SHORT_CHECK_AT] == CHECK_MARK)
                    begin
                        if (long_seen)
                        begin
                            word = {frame_buf[4], frame_buf[5], frame_buf[6], frame_buf[7]};
                            case (frame_buf[ID_AT])
                                SET_TIME:    time_set = word;
                                SET_REST:    rest_set = word;
                                SET_VERSION: version_set = word;
                                SET_BEAT:
                                begin
                                    beat_count = beat_count + 16'd1;
                                    if (beat_count > beat_limit)
                                    begin
                                        wifi_set = (frame_buf[LEN_AT] == WIFI_TAG);
                                        beat_count = '0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        got = 1'b1;
                        r = '{long_seen, frame_buf[ID_AT], frame_buf[VALUE_AT], time_set,
                              rest_set, version_set, beat_count, wifi_set};
                    end
                end
            end
        endcase
    endtask

    task automatic compose_frame(input logic is_long, input logic [7:0] len_byte,
                                 input logic [7:0] id, input logic [31:0] value,
                                 input logic [7:0] pad, input int lead, input fault_t fault,
                                 input logic [7:0] flip);
        logic [7:0] body [$];
        logic [7:0] sum;
        repeat (lead)
            frame_q.push_back(SYNC_A);
        body.push_back(SYNC_A);
        body.push_back(SYNC_B);
        body.push_back(is_long ? LONG_TAG : len_byte);
        body.push_back(id);
        body.push_back(value[31:24]);
        if (is_long)
        begin
            body.push_back(value[23:16]);
            body.push_back(value[15:8]);
            body.push_back(value[7:0]);
        end
        body.push_back(fault == FAULT_MARK ? CHECK_MARK ^ flip : CHECK_MARK);
        body.push_back(pad);
        sum = '0;
        foreach (body[i])
            sum = sum + body[i];
        body.push_back(fault == FAULT_SUM ? sum ^ flip : sum);
        foreach (body[i])
            frame_q.push_back(body[i]);
    endtask

    // Runs the predictor over the composed bytes and hands them to the sender.
    task automatic queue_frame(input check_t check, input frame_result_t want);
        bit            got;
        frame_result_t r;
        foreach (frame_q[i])
        begin
            parse_byte(frame_q[i], got, r);
            if (got && check == CHECK_MODEL)
                awaited_results.push_back(r);
            line_bytes.push_back(frame_q[i]);
        end
        if (check == CHECK_TYPED)
            awaited_results.push_back(want);
        bytes_queued += frame_q.size();
        frame_q.delete();
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (line_bytes.size() != 0 || rx_ch.valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [15:0] limits [6];
        int          phase_end;
        int          roll;
        logic        is_long;
        logic [7:0]  id;
        logic [7:0]  noise;
        logic [31:0] value;
        fault_t      fault;
        hunt = PH_IDLE;
        fill_idx = '0;
        long_seen = 1'b0;
        csum = '0;
        time_set = '0;
        rest_set = '0;
        version_set = '0;
        beat_count = '0;
        wifi_set = 1'b0;
        beat_limit = RESET_LIMIT;
        cfg_ch.valid = 1'b0;
        cfg_ch.heartbeat_limit = '0;
        limits = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(2, 6)),
                   16'($urandom_range(0, 65535)), 16'd3};

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            compose_frame(DIRECTED_ROWS[i].is_long, DIRECTED_ROWS[i].len_byte,
                          DIRECTED_ROWS[i].id, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].pad,
                          DIRECTED_ROWS[i].lead, DIRECTED_ROWS[i].fault, 8'h01);
            queue_frame(DIRECTED_ROWS[i].check, DIRECTED_ROWS[i].want);
        end

        foreach (limits[i])
        begin
            wait_idle();
            @(posedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.heartbeat_limit <= limits[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            cfg_ch.valid <= 1'b0;
            beat_limit = limits[i];
            @(negedge clk);

            // Mostly well-formed frames with random content, plus noise, faulty and cut frames.
            phase_end = bytes_queued + PHASE_BYTES;
            while (bytes_queued < phase_end)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    repeat ($urandom_range(1, 5))
                    begin
                        case ($urandom_range(0, 4))
                            0:       noise = SYNC_A;
                            1:       noise = SYNC_B;
                            2:       noise = LONG_TAG;
                            3:       noise = CHECK_MARK;
                            default: noise = 8'($urandom_range(0, 255));
                        endcase
                        frame_q.push_back(noise);
                    end
                end
                else
                begin
                    is_long = ($urandom_range(0, 2) != 0);
                    case ($urandom_range(0, 5))
                        0:       id = SET_TIME;
                        1:       id = SET_REST;
                        2:       id = SET_VERSION;
                        3, 4:    id = SET_BEAT;
                        default: id = 8'($urandom_range(0, 255));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       value = '0;
                        1:       value = '1;
                        default: value = $urandom;
                    endcase
                    if (roll < 18)
                        fault = FAULT_SUM;
                    else if (roll < 25)
                        fault = FAULT_MARK;
                    else
                        fault = FAULT_NONE;
                    compose_frame(is_long, 8'($urandom_range(0, 255)), id, value,
                                  8'($urandom_range(0, 255)),
                                  ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0,
                                  fault, 8'($urandom_range(1, 255)));
                    // A cut frame swallows the start of whatever follows it.
                    if (roll >= 25 && roll < 30)
                        repeat ($urandom_range(1, frame_q.size() - 2))
                            void'(frame_q.pop_back());
                end
                queue_frame(CHECK_MODEL, NO_RESULT);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Byte sender: bursts of random length separated by random gaps.
    initial
    begin : byte_sender
        int burst_left;
        int gap_left;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        burst_left = 0;
        gap_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_ch.valid && rx_ch.ready)
            begin
                void'(line_bytes.pop_front());
                bytes_accepted++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (hold_off)
                    gap_left = 0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    rx_ch.valid <= 1'b0;
                end
                else if (line_bytes.size() > 0)
                begin
                    rx_ch.valid <= 1'b1;
                    rx_ch.rx_byte <= line_bytes[0];
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: the stall pattern steps through four modes chosen from a running cycle counter.
    initial
    begin : result_receiver
        int cyc;
        res_ch.ready = 1'b0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_off)
                res_ch.ready <= 1'b0;
            else
                case ((cyc >> 7) % 4)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready <= (cyc % 3 != 0);
                    default: res_ch.ready <= 1'($urandom_range(0, 1));
                endcase
        end
    end

    // One long hold-off on the result side while the sender keeps offering bytes, so that
    // both internal stages fill and the input stalls.
    initial
    begin : long_hold
        do
            @(negedge clk);
        while (bytes_accepted < HOLD_AFTER_BYTES);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin : result_checker
        frame_result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result with none awaited", res_ch.event_id, '0);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (res_ch.frame_kind !== want.kind)
                    report_mismatch("frame_kind", res_ch.frame_kind, want.kind);
                if (res_ch.event_id !== want.id)
                    report_mismatch("event_id", res_ch.event_id, want.id);
                if (res_ch.event_value !== want.value)
                    report_mismatch("event_value", res_ch.event_value, want.value);
                if (res_ch.current_time !== want.time_val)
                    report_mismatch("current_time", res_ch.current_time, want.time_val);
                if (res_ch.rest_count !== want.rest)
                    report_mismatch("rest_count", res_ch.rest_count, want.rest);
                if (res_ch.api_version !== want.version)
                    report_mismatch("api_version", res_ch.api_version, want.version);
                if (res_ch.heartbeat_count !== want.beats)
                    report_mismatch("heartbeat_count", res_ch.heartbeat_count, want.beats);
                if (res_ch.wifi_flag !== want.wifi)
                    report_mismatch("wifi_flag", res_ch.wifi_flag, want.wifi);
            end
        end
    end

    // Ends the run when no transfer of any kind has happened for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
rtl/scfp_pkg.sv
rtl/scfp_if.sv
rtl/scfp_framer.sv
rtl/serial_command_frame_parser.sv
bench/tb_serial_command_frame_parser.sv
